// File: rtl/core/generational_handle_allocator_core_macros.svh
// Assertion macros shared by the allocator core.
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_CORE_MACROS_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GHA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GHA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/gha_pkg.sv
`timescale 1ns / 1ps

package gha_pkg;

	localparam logic [31:0] GEN_MAX = 32'hffff_ffff;

	localparam logic [6:0]  SLOTS_RESET  = 7'd64;
	localparam logic [63:0] MAX_RESET    = 64'h0000_0001_0000_0000;
	localparam logic [63:0] MIN_AL_RESET = 64'd4096;
	localparam logic [1:0]  DOM_RESET    = 2'b01;

	typedef enum logic [1:0] {
		REQ_ALLOC   = 2'd0,
		REQ_RELEASE = 2'd1,
		REQ_RESET   = 2'd2,
		REQ_UNKNOWN = 2'd3
	} req_type_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_INVALID     = 3'd1,
		ST_UNSUPPORTED = 3'd2,
		ST_EXHAUSTED   = 3'd3,
		ST_RANGE       = 3'd4,
		ST_ALIGNMENT   = 3'd5,
		ST_BAD_HANDLE  = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		CFG_SLOTS_IN_USE  = 2'd0,
		CFG_MAX_BUFFER    = 2'd1,
		CFG_MIN_ALIGN     = 2'd2,
		CFG_DOMAIN_ENABLE = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [63:0] size_bytes;
		logic [63:0] align_bytes;
		logic [7:0]  domain_bits;
		logic [7:0]  access_bits;
		logic [63:0] handle_in;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [63:0] handle_out;
	} rsp_t;

	// Controller to datapath
	typedef struct packed {
		logic clear;
		logic load;
		logic check;
		logic decide;
		logic scan;
		logic read;
		logic write;
		logic emit;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic clear_done;
		logic need_scan;
		logic found;
		logic scan_last;
		logic out_free;
	} stat_t;

endpackage

// File: rtl/core/generational_handle_allocator_core.sv
`timescale 1ns / 1ps
// Flow: each accepted request passes the check and decide states; release, reset, unknown and
// rejected allocate then go to done, while an allocate that passes its checks scans the 32-slot
// words in order and, on a free slot, reads and writes its generation, else ends exhausted.
// Throughput: one request in flight; the next is taken once the result is queued.
// Reset: arst_n clears control, config to defaults; then a sweep zeroes the generation
// memory one slot at a time while in_ready stays low (config writes still taken).
`include "generational_handle_allocator_core_macros.svh"

module generational_handle_allocator_core
	import gha_pkg::*;
#(
	parameter int SLOTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        in_valid,
	output logic        in_ready,
	input  req_t        req,
	// response channel
	output logic        out_valid,
	input  logic        out_ready,
	output rsp_t        rsp,
	// configuration writes
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [63:0] cfg_wdata
);

	// Command and status between the sequencer and the datapath. The sequencer walks
	// each request through check and decide; an allocate that passes scans and, if a slot
	// is found, does the memory read and generation write; then the result goes to the output register.
	cmd_t  cmd;
	stat_t stat;

	// Sequencer: one-hot state machine, owns in_ready.
	gha_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Datapath: config registers, live/exhausted bits, generation memory,
	// free-slot scan and the output register.
	gha_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.rsp       (rsp)
	);

	// Drop ready right after a request is taken.
	`GHA_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready, "ready held after accept")
	// Never more than one datapath command in a cycle.
	`GHA_ASSERT_NOW(a_cmd_onehot, clk, arst_n, 1'b1, $onehot0(cmd), "conflicting datapath commands")
	// Never overwrite a result that has not been taken.
	`GHA_ASSERT_NOW(a_emit_free, clk, arst_n, cmd.emit, stat.out_free, "result overwritten")
	// No request before the generation sweep has finished.
	`GHA_ASSERT_NOW(a_accept_after_clear, clk, arst_n, in_valid && in_ready, stat.clear_done, "accept during clear")

endmodule

// File: rtl/core/gha_ctrl.sv
`timescale 1ns / 1ps

module gha_ctrl
	import gha_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	typedef enum logic [7:0] {
		S_CLEAR  = 8'b0000_0001,
		S_IDLE   = 8'b0000_0010,
		S_CHECK  = 8'b0000_0100,
		S_DECIDE = 8'b0000_1000,
		S_SCAN   = 8'b0001_0000,
		S_READ   = 8'b0010_0000,
		S_WRITE  = 8'b0100_0000,
		S_DONE   = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (stat.clear_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				state_d   = S_DECIDE;
			end
			S_DECIDE: begin
				cmd.decide = 1'b1;
				state_d    = stat.need_scan ? S_SCAN : S_DONE;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				priority if (stat.found) state_d = S_READ;
				else if (stat.scan_last) state_d = S_DONE;
				else                     state_d = S_SCAN;
			end
			S_READ: begin
				cmd.read = 1'b1;
				state_d  = S_WRITE;
			end
			S_WRITE: begin
				cmd.write = 1'b1;
				state_d   = S_DONE;
			end
			S_DONE: begin
				// hold the result until the output register frees up
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

endmodule

// File: rtl/core/gha_dp.sv
`timescale 1ns / 1ps

module gha_dp
	import gha_pkg::*;
#(
	parameter int SLOTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  req_t        req,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [63:0] cfg_wdata,
	input  cmd_t        cmd,
	output stat_t       stat,
	output logic        out_valid,
	input  logic        out_ready,
	output rsp_t        rsp
);

	localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int WORDS = (SLOTS + 31) / 32;
	localparam int WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int PADW  = WORDS * 32;

	// configuration
	logic [6:0]  slots_q;
	logic [63:0] max_q;
	logic [63:0] min_al_q;
	logic [1:0]  dom_en_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_q  <= SLOTS_RESET;
			max_q    <= MAX_RESET;
			min_al_q <= MIN_AL_RESET;
			dom_en_q <= DOM_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_idx))
				CFG_SLOTS_IN_USE:  slots_q  <= cfg_wdata[6:0];
				CFG_MAX_BUFFER:    max_q    <= cfg_wdata;
				CFG_MIN_ALIGN:     min_al_q <= cfg_wdata;
				CFG_DOMAIN_ENABLE: dom_en_q <= cfg_wdata[1:0];
			endcase
		end
	end

	// request register
	req_t req_q;

	always_ff @(posedge clk) begin
		if (cmd.load) req_q <= req;
	end

	// slot state
	logic [SLOTS-1:0] live_q;
	logic [SLOTS-1:0] exh_q;
	logic             stopped_q;
	logic [IW-1:0]    clr_q;
	logic [IW-1:0]    found_q;
	logic [WW-1:0]    word_q;

	// first-stage checks
	logic        nrdy_q, size_bad_q, align_bad_q, ovf_q, rel_bad_q;
	logic [63:0] rounded_q;

	logic [63:0] am1;
	logic [64:0] sum;
	logic [31:0] low;
	logic [31:0] low_m1;
	logic [IW-1:0] rel_slot;
	logic        nrdy;

	assign am1      = req_q.align_bytes - 64'd1;
	assign sum      = {1'b0, req_q.size_bytes} + {1'b0, am1};
	assign low      = req_q.handle_in[31:0];
	assign low_m1   = low - 32'd1;
	assign rel_slot = low_m1[IW-1:0];
	assign nrdy     = !((slots_q != 7'd0) && ({25'd0, slots_q} <= 32'(SLOTS)) &&
			(max_q != 64'd0) && (min_al_q != 64'd0) && !stopped_q);

	always_ff @(posedge clk) begin
		if (cmd.check) begin
			nrdy_q      <= nrdy;
			size_bad_q  <= (req_q.size_bytes == 64'd0) || (req_q.size_bytes > max_q);
			align_bad_q <= (req_q.align_bytes == 64'd0) ||
					((req_q.align_bytes & am1) != 64'd0) ||
					(req_q.align_bytes < min_al_q);
			ovf_q       <= sum[64];
			rounded_q   <= sum[63:0] & ~am1;
			rel_bad_q   <= nrdy || (low == 32'd0) || (low > {25'd0, slots_q}) ||
					(low > 32'(SLOTS));
		end
	end

	// generation memory
	logic [31:0] gen_mem [SLOTS];
	logic [31:0] gen_rd_q;
	logic        mem_we, mem_re;
	logic [IW-1:0] mem_wa, mem_ra;
	logic [31:0] mem_wd;
	logic [31:0] gen_new;

	assign gen_new = gen_rd_q + 32'd1;
	assign mem_we  = cmd.clear || cmd.write;
	assign mem_wa  = cmd.clear ? clr_q : found_q;
	assign mem_wd  = cmd.clear ? 32'd0 : gen_new;
	assign mem_re  = cmd.check || cmd.read;
	assign mem_ra  = cmd.read ? found_q : rel_slot;

	always_ff @(posedge clk) begin
		if (mem_we) gen_mem[mem_wa] <= mem_wd;
		if (mem_re) gen_rd_q <= gen_mem[mem_ra];
	end

	// allocate verdict, in check order
	status_t alloc_st;

	always_comb begin
		priority if (nrdy_q)                                  alloc_st = ST_EXHAUSTED;
		else if (size_bad_q)                                  alloc_st = ST_RANGE;
		else if (align_bad_q)                                 alloc_st = ST_ALIGNMENT;
		else if (ovf_q)                                       alloc_st = ST_RANGE;
		else if (rounded_q > max_q)                           alloc_st = ST_RANGE;
		else if (req_q.domain_bits[7:2] != 6'd0)              alloc_st = ST_INVALID;
		else if ((req_q.domain_bits != 8'd1) || !dom_en_q[0]) alloc_st = ST_UNSUPPORTED;
		else if ((req_q.access_bits[7:3] != 5'd0) || (req_q.access_bits == 8'd0))
			alloc_st = ST_INVALID;
		else if (req_q.access_bits[2])                        alloc_st = ST_UNSUPPORTED;
		else if (req_q.access_bits[1:0] == 2'd0)              alloc_st = ST_UNSUPPORTED;
		else                                                  alloc_st = ST_OK;
	end

	logic rel_ok;
	assign rel_ok = !rel_bad_q && live_q[rel_slot] && (gen_rd_q == req_q.handle_in[63:32]);

	// free-slot scan, one 32-slot word per cycle
	logic [SLOTS-1:0] avail;
	logic [PADW-1:0]  free_pad;
	logic [31:0]      free_word;
	logic [4:0]       pe_pos;
	logic             pe_hit;

	always_comb begin
		for (int i = 0; i < SLOTS; i++) avail[i] = (i < int'(slots_q));
	end

	assign free_pad  = PADW'(~live_q & ~exh_q & avail);
	assign free_word = free_pad[word_q*32 +: 32];

	always_comb begin
		pe_pos = 5'd0;
		for (int b = 31; b >= 0; b--) begin
			if (free_word[b]) pe_pos = 5'(b);
		end
	end
	assign pe_hit = (free_word != 32'd0);

	// result and slot updates
	logic [2:0]  res_status_q;
	logic [63:0] res_handle_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q    <= '0;
			exh_q     <= '0;
			stopped_q <= 1'b0;
			clr_q     <= '0;
			word_q    <= '0;
		end else begin
			if (cmd.clear && !stat.clear_done) clr_q <= clr_q + IW'(1);
			if (cmd.check) word_q <= '0;
			if (cmd.scan && !pe_hit && !stat.scan_last) word_q <= word_q + WW'(1);
			if (cmd.decide) begin
				if (req_q.req_type == REQ_RESET) begin
					live_q    <= '0;
					stopped_q <= 1'b1;
				end else if ((req_q.req_type == REQ_RELEASE) && rel_ok) begin
					live_q[rel_slot] <= 1'b0;
				end
			end
			if (cmd.write) begin
				live_q[found_q] <= 1'b1;
				if (gen_new == GEN_MAX) exh_q[found_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan && pe_hit) found_q <= IW'({word_q, pe_pos});
		if (cmd.decide) begin
			res_handle_q <= 64'd0;
			unique case (req_type_t'(req_q.req_type))
				REQ_ALLOC:   res_status_q <= alloc_st;
				REQ_RELEASE: res_status_q <= rel_ok ? ST_OK : ST_BAD_HANDLE;
				REQ_RESET:   res_status_q <= ST_OK;
				REQ_UNKNOWN: res_status_q <= ST_INVALID;
			endcase
		end
		if (cmd.scan && !pe_hit && stat.scan_last) res_status_q <= ST_EXHAUSTED;
		if (cmd.write) begin
			res_status_q <= ST_OK;
			res_handle_q <= {gen_new, {{(32-IW){1'b0}}, found_q} + 32'd1};
		end
	end

	// output register
	logic out_valid_q;
	rsp_t rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rsp_q.status     <= res_status_q;
			rsp_q.handle_out <= res_handle_q;
		end
	end

	assign out_valid = out_valid_q;
	assign rsp       = rsp_q;

	assign stat.clear_done = (clr_q == IW'(SLOTS - 1));
	assign stat.need_scan  = (req_q.req_type == REQ_ALLOC) && (alloc_st == ST_OK);
	assign stat.found      = pe_hit;
	assign stat.scan_last  = (word_q == WW'(WORDS - 1));
	assign stat.out_free   = !out_valid_q || out_ready;

endmodule
